// File: src/pcuf_pkg.sv
`default_nettype none

package pcuf_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_GHDR,
    PH_RHDR,
    PH_HDRS,
    PH_PAY,
    PH_SKIP
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_EOF     = 2'd3
  } kind_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_NOT_PCAP         = 3'd1,
    ST_LINK_UNSUPPORTED = 3'd2,
    ST_TOO_LARGE        = 3'd3,
    ST_TRUNCATED        = 3'd4,
    ST_MALFORMED        = 3'd5
  } status_t;

  // File format constants
  localparam logic [31:0] MAGIC_BIG     = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_LITTLE  = 32'hd4c3b2a1;
  localparam logic [31:0] LINK_ETHERNET = 32'd1;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [31:0] IP_HDR_END    = 32'd34;
  localparam logic [31:0] UDP_HDR_END   = 32'd42;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

  // Byte positions in the global header and record header
  localparam logic [4:0] GHDR_MAGIC_END = 5'd3;
  localparam logic [4:0] GHDR_END       = 5'd23;
  localparam logic [4:0] RHDR_LEN_END   = 5'd11;
  localparam logic [4:0] RHDR_END       = 5'd15;

  // Byte positions inside the record body
  localparam logic [31:0] POS_PROTO        = 32'd23;
  localparam logic [31:0] POS_IP_SRC_END   = 32'd29;
  localparam logic [31:0] POS_IP_DST_END   = 32'd33;
  localparam logic [31:0] POS_SRC_PORT_END = 32'd35;
  localparam logic [31:0] POS_DST_PORT_END = 32'd37;
  localparam logic [31:0] POS_UDP_LEN_END  = 32'd39;
  localparam logic [31:0] POS_UDP_END      = 32'd41;

  // Register map
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_FILTER_LINK     = 3'd0;
  localparam logic [2:0] REG_FILTER_IP_SRC   = 3'd1;
  localparam logic [2:0] REG_FILTER_IP_DST   = 3'd2;
  localparam logic [2:0] REG_FILTER_PROTO    = 3'd3;
  localparam logic [2:0] REG_FILTER_SRC_PORT = 3'd4;
  localparam logic [2:0] REG_FILTER_DST_PORT = 3'd5;
  localparam logic [2:0] REG_MAX_PAYLOAD     = 3'd6;
  localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd1500;

  // Result queue sizing: room for two in-flight items of two results each
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam logic [FIFO_CNT_W-1:0] FIFO_READY_MAX = FIFO_CNT_W'(FIFO_DEPTH - 4);

  typedef struct packed {
    logic [15:0] filter_link;
    logic [31:0] filter_ip_src;
    logic [31:0] filter_ip_dst;
    logic [7:0]  filter_proto;
    logic [15:0] filter_src_port;
    logic [15:0] filter_dst_port;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_of_packet;
    status_t     status;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
  } result_t;

  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic result_t make_result(input kind_t k, input status_t s,
                                          input logic [15:0] sp, input logic [15:0] dp,
                                          input logic [15:0] len);
    result_t r;
    r.kind           = k;
    r.payload_byte   = 8'd0;
    r.last_of_packet = 1'b0;
    r.status         = s;
    r.src_port       = sp;
    r.dst_port       = dp;
    r.payload_len    = len;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/pcap_udp_record_filter.sv
// A result reaches the master side via the parser's input register and result queue.
// Throughput: one capture byte per cycle; a final byte that also carries a result
// yields two results, and the eight-entry result queue absorbs that burst.
// The slave side stalls only when the result queue holds more than four entries.
// Reset (rst, synchronous): parser returns to the global header, registers to defaults.
`default_nettype none

module pcap_udp_record_filter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Capture byte stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,  // [7:0] in_byte
  input  wire logic                            s_tlast,  // end_of_file
  // Result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [63:0]                     m_tdata,  // [7:0] payload_byte,
                                                         // [10:8] status,
                                                         // [26:11] src_port,
                                                         // [42:27] dst_port,
                                                         // [58:43] payload_len
  output logic      [1:0]                      m_tuser,  // kind
  output logic                                 m_tlast,  // last_of_packet
  // Configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pcuf_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  pcuf_pkg::cfg_t    cfg;
  pcuf_pkg::push_t   push;
  pcuf_pkg::result_t head;
  logic [pcuf_pkg::FIFO_CNT_W-1:0] level;
  logic                            in_load;

  // Accept a byte only while two in-flight items still fit in the queue
  assign s_tready = (level <= pcuf_pkg::FIFO_READY_MAX);
  assign in_load  = s_tvalid & s_tready;

  pcuf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcuf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_load (in_load),
    .in_byte (s_tdata),
    .in_eof  (s_tlast),
    .cfg     (cfg),
    .push    (push)
  );

  pcuf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (m_tready),
    .head       (head),
    .head_valid (m_tvalid),
    .level      (level)
  );

  // Pack the queue head onto the result stream
  assign m_tdata = {5'd0, head.payload_len, head.dst_port, head.src_port,
                    head.status, head.payload_byte};
  assign m_tuser = head.kind;
  assign m_tlast = head.last_of_packet;

endmodule

`default_nettype wire

// File: src/pcuf_regs.sv
`default_nettype none

module pcuf_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pcuf_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output pcuf_pkg::cfg_t                      cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[pcuf_pkg::CFG_ADDR_W-1:2];

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_link     <= 16'd0;
      cfg.filter_ip_src   <= 32'd0;
      cfg.filter_ip_dst   <= 32'd0;
      cfg.filter_proto    <= 8'd0;
      cfg.filter_src_port <= 16'd0;
      cfg.filter_dst_port <= 16'd0;
      cfg.max_payload     <= pcuf_pkg::MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        pcuf_pkg::REG_FILTER_LINK:     cfg.filter_link     <= pwdata[15:0];
        pcuf_pkg::REG_FILTER_IP_SRC:   cfg.filter_ip_src   <= pwdata;
        pcuf_pkg::REG_FILTER_IP_DST:   cfg.filter_ip_dst   <= pwdata;
        pcuf_pkg::REG_FILTER_PROTO:    cfg.filter_proto    <= pwdata[7:0];
        pcuf_pkg::REG_FILTER_SRC_PORT: cfg.filter_src_port <= pwdata[15:0];
        pcuf_pkg::REG_FILTER_DST_PORT: cfg.filter_dst_port <= pwdata[15:0];
        pcuf_pkg::REG_MAX_PAYLOAD:     cfg.max_payload     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      pcuf_pkg::REG_FILTER_LINK:     prdata = {16'd0, cfg.filter_link};
      pcuf_pkg::REG_FILTER_IP_SRC:   prdata = cfg.filter_ip_src;
      pcuf_pkg::REG_FILTER_IP_DST:   prdata = cfg.filter_ip_dst;
      pcuf_pkg::REG_FILTER_PROTO:    prdata = {24'd0, cfg.filter_proto};
      pcuf_pkg::REG_FILTER_SRC_PORT: prdata = {16'd0, cfg.filter_src_port};
      pcuf_pkg::REG_FILTER_DST_PORT: prdata = {16'd0, cfg.filter_dst_port};
      pcuf_pkg::REG_MAX_PAYLOAD:     prdata = {16'd0, cfg.max_payload};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/pcuf_parser.sv
`default_nettype none

module pcuf_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_load,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_eof,
  input  wire pcuf_pkg::cfg_t cfg,
  output pcuf_pkg::push_t     push
);

  // Input register
  logic       in_valid;
  logic [7:0] byte_r;
  logic       eof_r;

  // Parser state
  pcuf_pkg::phase_t phase, phase_next;
  logic [4:0]  byte_pos, byte_pos_next;
  logic        swap_order, swap_order_next;
  logic [31:0] record_len, record_len_next;
  logic [31:0] bytes_consumed, bytes_consumed_next;
  logic [31:0] word_shift, word_shift_next;
  logic        mismatch, mismatch_next;
  logic [7:0]  ip_proto, ip_proto_next;
  logic [15:0] cur_src_port, cur_src_port_next;
  logic [15:0] cur_dst_port, cur_dst_port_next;
  logic [15:0] payload_left, payload_left_next;
  logic [15:0] pay_total, pay_total_next;
  logic        halted, halted_next;

  // Register the accepted byte for the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_load;
    end
    if (in_load) begin
      byte_r <= in_byte;
      eof_r  <= in_eof;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pcuf_pkg::PH_GHDR;
      byte_pos       <= 5'd0;
      swap_order     <= 1'b0;
      record_len     <= 32'd0;
      bytes_consumed <= 32'd0;
      word_shift     <= 32'd0;
      mismatch       <= 1'b0;
      ip_proto       <= 8'd0;
      cur_src_port   <= 16'd0;
      cur_dst_port   <= 16'd0;
      payload_left   <= 16'd0;
      pay_total      <= 16'd0;
      halted         <= 1'b0;
    end else begin
      phase          <= phase_next;
      byte_pos       <= byte_pos_next;
      swap_order     <= swap_order_next;
      record_len     <= record_len_next;
      bytes_consumed <= bytes_consumed_next;
      word_shift     <= word_shift_next;
      mismatch       <= mismatch_next;
      ip_proto       <= ip_proto_next;
      cur_src_port   <= cur_src_port_next;
      cur_dst_port   <= cur_dst_port_next;
      payload_left   <= payload_left_next;
      pay_total      <= pay_total_next;
      halted         <= halted_next;
    end
  end

  // Next state and results for the held byte
  always_comb begin
    logic [31:0] word_n;
    logic [31:0] word_sw;
    logic        halt_now;
    logic        mm;
    logic [15:0] pay;
    logic [15:0] pl_dec;
    logic        in_body;

    word_n  = {word_shift[23:0], byte_r};
    word_sw = swap_order ? pcuf_pkg::bswap32(word_n) : word_n;
    halt_now = 1'b0;
    mm       = 1'b0;
    pay      = pay_total - pcuf_pkg::UDP_HDR_LEN;
    pl_dec   = payload_left - 16'd1;
    in_body  = 1'b0;

    phase_next          = phase;
    byte_pos_next       = byte_pos;
    swap_order_next     = swap_order;
    record_len_next     = record_len;
    bytes_consumed_next = bytes_consumed;
    word_shift_next     = word_shift;
    mismatch_next       = mismatch;
    ip_proto_next       = ip_proto;
    cur_src_port_next   = cur_src_port;
    cur_dst_port_next   = cur_dst_port;
    payload_left_next   = payload_left;
    pay_total_next      = pay_total;
    halted_next         = halted;

    push.first_valid  = 1'b0;
    push.second_valid = 1'b0;
    push.first  = pcuf_pkg::make_result(pcuf_pkg::KIND_STATUS, pcuf_pkg::ST_OK,
                                        16'd0, 16'd0, 16'd0);
    push.second = pcuf_pkg::make_result(pcuf_pkg::KIND_EOF, pcuf_pkg::ST_OK,
                                        16'd0, 16'd0, 16'd0);

    if (in_valid && !halted) begin
      word_shift_next = word_n;
      unique case (phase)
        pcuf_pkg::PH_GHDR: begin
          // Check magic, then link type
          if (byte_pos == pcuf_pkg::GHDR_MAGIC_END) begin
            if (word_n == pcuf_pkg::MAGIC_LITTLE) begin
              swap_order_next = 1'b1;
            end else if (word_n == pcuf_pkg::MAGIC_BIG) begin
              swap_order_next = 1'b0;
            end else begin
              push.first_valid = 1'b1;
              push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_STATUS,
                             pcuf_pkg::ST_NOT_PCAP, 16'd0, 16'd0, 16'd0);
              halt_now = 1'b1;
            end
          end
          if (!halt_now && byte_pos == pcuf_pkg::GHDR_END) begin
            if (word_sw != pcuf_pkg::LINK_ETHERNET ||
                (cfg.filter_link != 16'd0 && word_sw != {16'd0, cfg.filter_link})) begin
              push.first_valid = 1'b1;
              push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_STATUS,
                             pcuf_pkg::ST_LINK_UNSUPPORTED, 16'd0, 16'd0, 16'd0);
              halt_now = 1'b1;
            end else begin
              phase_next    = pcuf_pkg::PH_RHDR;
              byte_pos_next = 5'd0;
            end
          end else if (!halt_now) begin
            byte_pos_next = byte_pos + 5'd1;
          end
          halted_next = halt_now;
        end
        pcuf_pkg::PH_RHDR: begin
          // Capture the record length, then decide on the record
          if (byte_pos == pcuf_pkg::RHDR_LEN_END) begin
            record_len_next = word_sw;
          end
          if (byte_pos == pcuf_pkg::RHDR_END) begin
            byte_pos_next       = 5'd0;
            bytes_consumed_next = 32'd0;
            mismatch_next       = 1'b0;
            if (record_len < pcuf_pkg::IP_HDR_END) begin
              push.first_valid = 1'b1;
              push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_STATUS,
                             pcuf_pkg::ST_MALFORMED, 16'd0, 16'd0, 16'd0);
              phase_next = (record_len != 32'd0) ? pcuf_pkg::PH_SKIP : pcuf_pkg::PH_RHDR;
            end else begin
              phase_next = pcuf_pkg::PH_HDRS;
            end
          end else begin
            byte_pos_next = byte_pos + 5'd1;
          end
        end
        pcuf_pkg::PH_HDRS: begin
          // Walk Ethernet, IPv4 and UDP headers
          bytes_consumed_next = bytes_consumed + 32'd1;
          if (bytes_consumed == pcuf_pkg::POS_PROTO) begin
            ip_proto_next = byte_r;
          end else if (bytes_consumed == pcuf_pkg::POS_IP_SRC_END) begin
            if (cfg.filter_ip_src != 32'd0 && word_n != cfg.filter_ip_src) begin
              mismatch_next = 1'b1;
            end
          end else if (bytes_consumed == pcuf_pkg::POS_IP_DST_END) begin
            mm = mismatch
               | (cfg.filter_ip_dst != 32'd0 && word_n != cfg.filter_ip_dst)
               | (cfg.filter_proto != 8'd0 && ip_proto != cfg.filter_proto)
               | (ip_proto != pcuf_pkg::PROTO_UDP);
            mismatch_next = mm;
            if (mm) begin
              phase_next = pcuf_pkg::PH_SKIP;
            end else if (record_len < pcuf_pkg::UDP_HDR_END) begin
              push.first_valid = 1'b1;
              push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_STATUS,
                             pcuf_pkg::ST_MALFORMED, 16'd0, 16'd0, 16'd0);
              phase_next = pcuf_pkg::PH_SKIP;
            end
          end else if (bytes_consumed == pcuf_pkg::POS_SRC_PORT_END) begin
            cur_src_port_next = word_n[15:0];
          end else if (bytes_consumed == pcuf_pkg::POS_DST_PORT_END) begin
            cur_dst_port_next = word_n[15:0];
          end else if (bytes_consumed == pcuf_pkg::POS_UDP_LEN_END) begin
            pay_total_next = word_n[15:0];
          end else if (bytes_consumed == pcuf_pkg::POS_UDP_END) begin
            if ((cfg.filter_src_port != 16'd0 && cur_src_port != cfg.filter_src_port) ||
                (cfg.filter_dst_port != 16'd0 && cur_dst_port != cfg.filter_dst_port)) begin
              phase_next = pcuf_pkg::PH_SKIP;
            end else if (pay_total < pcuf_pkg::UDP_HDR_LEN ||
                         {16'd0, pay} > (record_len - pcuf_pkg::UDP_HDR_END)) begin
              push.first_valid = 1'b1;
              push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_STATUS,
                             pcuf_pkg::ST_MALFORMED, 16'd0, 16'd0, 16'd0);
              phase_next = pcuf_pkg::PH_SKIP;
            end else begin
              pay_total_next = pay;
              if (pay > cfg.max_payload) begin
                push.first_valid = 1'b1;
                push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_STATUS,
                               pcuf_pkg::ST_TOO_LARGE, cur_src_port, cur_dst_port, pay);
                phase_next = pcuf_pkg::PH_SKIP;
              end else if (pay == 16'd0) begin
                push.first_valid = 1'b1;
                push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_EMPTY,
                               pcuf_pkg::ST_OK, cur_src_port, cur_dst_port, 16'd0);
                phase_next = pcuf_pkg::PH_SKIP;
              end else begin
                payload_left_next = pay;
                phase_next        = pcuf_pkg::PH_PAY;
              end
            end
          end
        end
        pcuf_pkg::PH_PAY: begin
          // Send one payload byte
          bytes_consumed_next = bytes_consumed + 32'd1;
          payload_left_next   = pl_dec;
          push.first_valid    = 1'b1;
          push.first = pcuf_pkg::make_result(pcuf_pkg::KIND_PAYLOAD, pcuf_pkg::ST_OK,
                         cur_src_port, cur_dst_port, pay_total);
          push.first.payload_byte   = byte_r;
          push.first.last_of_packet = (pl_dec == 16'd0);
          if (pl_dec == 16'd0) begin
            phase_next = pcuf_pkg::PH_SKIP;
          end
        end
        pcuf_pkg::PH_SKIP: begin
          bytes_consumed_next = bytes_consumed + 32'd1;
        end
        default: ;
      endcase

      // Close the record once its length is used up
      in_body = (phase_next == pcuf_pkg::PH_HDRS) || (phase_next == pcuf_pkg::PH_PAY) ||
                (phase_next == pcuf_pkg::PH_SKIP);
      if (in_body && bytes_consumed_next >= record_len_next) begin
        phase_next    = pcuf_pkg::PH_RHDR;
        byte_pos_next = 5'd0;
      end
    end

    // End of file: report, then return to the start-of-file state
    if (in_valid && eof_r) begin
      push.second_valid = 1'b1;
      if (!halted_next &&
          !(phase_next == pcuf_pkg::PH_RHDR && byte_pos_next == 5'd0)) begin
        push.second.status = pcuf_pkg::ST_TRUNCATED;
      end
      phase_next          = pcuf_pkg::PH_GHDR;
      byte_pos_next       = 5'd0;
      swap_order_next     = 1'b0;
      record_len_next     = 32'd0;
      bytes_consumed_next = 32'd0;
      word_shift_next     = 32'd0;
      mismatch_next       = 1'b0;
      ip_proto_next       = 8'd0;
      cur_src_port_next   = 16'd0;
      cur_dst_port_next   = 16'd0;
      payload_left_next   = 16'd0;
      pay_total_next      = 16'd0;
      halted_next         = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/pcuf_fifo.sv
`default_nettype none

module pcuf_fifo (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pcuf_pkg::push_t                   push,
  input  wire logic                              pop,
  output pcuf_pkg::result_t                      head,
  output logic                                   head_valid,
  output logic      [pcuf_pkg::FIFO_CNT_W-1:0]   level
);

  pcuf_pkg::result_t mem [pcuf_pkg::FIFO_DEPTH];

  logic [pcuf_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [pcuf_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [1:0]                      n_push;
  logic                            do_pop;

  assign n_push     = {1'b0, push.first_valid} + {1'b0, push.second_valid};
  assign head_valid = (level != '0);
  assign do_pop     = pop & head_valid;
  assign head       = mem[rd_ptr];

  // Store up to two results per cycle, in order
  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[wr_ptr + pcuf_pkg::FIFO_PTR_W'(push.first_valid)] <= push.second;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pcuf_pkg::FIFO_PTR_W'(n_push);
      rd_ptr <= rd_ptr + pcuf_pkg::FIFO_PTR_W'(do_pop);
      level  <= level + pcuf_pkg::FIFO_CNT_W'(n_push) - pcuf_pkg::FIFO_CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_pcap_udp_record_filter.sv
`timescale 1ns / 100ps

module tb_pcap_udp_record_filter;
  import pcuf_pkg::*;

  // Capture format values
  localparam logic [31:0] WORD_MAGIC_NATIVE  = 32'ha1b2c3d4;
  localparam logic [31:0] WORD_MAGIC_SWAPPED = 32'hd4c3b2a1;
  localparam logic [31:0] LINK_ETH           = 32'd1;
  localparam logic [7:0]  UDP_PROTO          = 8'd17;
  localparam int unsigned IP_END             = 34;
  localparam int unsigned UDP_END            = 42;
  localparam int unsigned UDP_HDR_BYTES      = 8;

  // Byte offsets in the global header, record header and record body
  localparam int unsigned AT_MAGIC_LAST = 3;
  localparam int unsigned AT_GHDR_LAST  = 23;
  localparam int unsigned AT_RLEN_LAST  = 11;
  localparam int unsigned AT_RHDR_LAST  = 15;
  localparam int unsigned AT_PROTO      = 23;
  localparam int unsigned AT_SRC_LAST   = 29;
  localparam int unsigned AT_DST_LAST   = 33;
  localparam int unsigned AT_SPORT_LAST = 35;
  localparam int unsigned AT_DPORT_LAST = 37;
  localparam int unsigned AT_ULEN_LAST  = 39;
  localparam int unsigned AT_UDP_LAST   = 41;

  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASE_BYTES   = 340;

  typedef struct packed {
    logic [7:0] data;
    logic       file_end;
  } capture_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  pcap_udp_record_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Stimulus and scoreboard storage
  capture_item_t capture_bytes[$];
  result_t       expected_results[$];
  logic [7:0]    file_buf[$];
  int unsigned   bytes_queued = 0;
  int unsigned   bytes_accepted = 0;
  int unsigned   phase_bytes = 0;
  int unsigned   errors = 0;
  int unsigned   send_idle_pct = 17;
  int unsigned   recv_idle_pct = 58;
  logic          long_hold_req = 1'b0;
  int unsigned   hold_left = 0;

  // Register copies used by the parser prediction
  logic [15:0] cfg_link;
  logic [31:0] cfg_ip_src;
  logic [31:0] cfg_ip_dst;
  logic [7:0]  cfg_proto;
  logic [15:0] cfg_src_port;
  logic [15:0] cfg_dst_port;
  logic [15:0] cfg_max_pay;

  // Parser state of the prediction
  phase_t      p_phase;
  logic [15:0] p_pos;
  logic        p_swap;
  logic [31:0] p_link;
  logic [31:0] p_rec_len;
  logic [31:0] p_consumed;
  logic [31:0] p_shift;
  logic        p_miss;
  logic [7:0]  p_proto;
  logic [15:0] p_sport;
  logic [15:0] p_dport;
  logic [15:0] p_left;
  logic [15:0] p_pay_len;
  logic        p_halted;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[pcap_udp_record_filter] ERROR");
    $finish;
  end

  function automatic logic [31:0] flip_bytes(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = v[8*(3-k) +: 8];
    return r;
  endfunction

  function automatic void clear_parser();
    p_phase    = PH_GHDR;
    p_pos      = '0;
    p_swap     = 1'b0;
    p_link     = '0;
    p_rec_len  = '0;
    p_consumed = '0;
    p_shift    = '0;
    p_miss     = 1'b0;
    p_proto    = '0;
    p_sport    = '0;
    p_dport    = '0;
    p_left     = '0;
    p_pay_len  = '0;
    p_halted   = 1'b0;
  endfunction

  function automatic void expect_result(input kind_t k, input logic [7:0] pb,
                                        input logic lst, input status_t st,
                                        input logic [15:0] sp, input logic [15:0] dp,
                                        input logic [15:0] len);
    result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.last_of_packet = lst;
    r.status         = st;
    r.src_port       = sp;
    r.dst_port       = dp;
    r.payload_len    = len;
    expected_results.push_back(r);
  endfunction

  // Advance the parser by one capture byte and queue the results it causes
  function automatic void parse_capture_byte(input logic [7:0] b, input logic file_end);
    logic [31:0] word_val;
    logic [31:0] pos;
    logic [31:0] udp_len;
    status_t     end_st;
    if (!p_halted) begin
      p_shift = {p_shift[23:0], b};
      case (p_phase)
        PH_GHDR: begin
          if (p_pos == AT_MAGIC_LAST) begin
            if (p_shift == WORD_MAGIC_SWAPPED) p_swap = 1'b1;
            else if (p_shift == WORD_MAGIC_NATIVE) p_swap = 1'b0;
            else begin
              expect_result(KIND_STATUS, 8'd0, 1'b0, ST_NOT_PCAP, 16'd0, 16'd0, 16'd0);
              p_halted = 1'b1;
            end
          end
          if (!p_halted && p_pos == AT_GHDR_LAST) begin
            p_link = p_swap ? flip_bytes(p_shift) : p_shift;
            if (p_link != LINK_ETH || (cfg_link != 16'd0 && p_link != {16'd0, cfg_link})) begin
              expect_result(KIND_STATUS, 8'd0, 1'b0, ST_LINK_UNSUPPORTED,
                            16'd0, 16'd0, 16'd0);
              p_halted = 1'b1;
            end else begin
              p_phase = PH_RHDR;
              p_pos   = '0;
            end
          end else if (!p_halted) begin
            p_pos = p_pos + 16'd1;
          end
        end
        PH_RHDR: begin
          word_val = p_swap ? flip_bytes(p_shift) : p_shift;
          if (p_pos == AT_RLEN_LAST) p_rec_len = word_val;
          if (p_pos == AT_RHDR_LAST) begin
            p_pos      = '0;
            p_consumed = '0;
            p_miss     = 1'b0;
            if (p_rec_len < IP_END) begin
              expect_result(KIND_STATUS, 8'd0, 1'b0, ST_MALFORMED, 16'd0, 16'd0, 16'd0);
              if (p_rec_len != 0) p_phase = PH_SKIP;
              else p_phase = PH_RHDR;
            end else begin
              p_phase = PH_HDRS;
            end
          end else begin
            p_pos = p_pos + 16'd1;
          end
        end
        PH_HDRS: begin
          pos = p_consumed;
          p_consumed = p_consumed + 1;
          if (pos == AT_PROTO) begin
            p_proto = b;
          end else if (pos == AT_SRC_LAST) begin
            if (cfg_ip_src != 0 && p_shift != cfg_ip_src) p_miss = 1'b1;
          end else if (pos == AT_DST_LAST) begin
            if (cfg_ip_dst != 0 && p_shift != cfg_ip_dst) p_miss = 1'b1;
            if (cfg_proto != 0 && p_proto != cfg_proto) p_miss = 1'b1;
            if (p_proto != UDP_PROTO) p_miss = 1'b1;
            if (p_miss) begin
              p_phase = PH_SKIP;
            end else if (p_rec_len < UDP_END) begin
              expect_result(KIND_STATUS, 8'd0, 1'b0, ST_MALFORMED, 16'd0, 16'd0, 16'd0);
              p_phase = PH_SKIP;
            end
          end else if (pos == AT_SPORT_LAST) begin
            p_sport = p_shift[15:0];
          end else if (pos == AT_DPORT_LAST) begin
            p_dport = p_shift[15:0];
          end else if (pos == AT_ULEN_LAST) begin
            p_pay_len = p_shift[15:0];
          end else if (pos == AT_UDP_LAST) begin
            udp_len = {16'd0, p_pay_len};
            if ((cfg_src_port != 0 && p_sport != cfg_src_port) ||
                (cfg_dst_port != 0 && p_dport != cfg_dst_port)) begin
              p_phase = PH_SKIP;
            end else if (udp_len < UDP_HDR_BYTES ||
                         udp_len - UDP_HDR_BYTES > p_rec_len - UDP_END) begin
              expect_result(KIND_STATUS, 8'd0, 1'b0, ST_MALFORMED, 16'd0, 16'd0, 16'd0);
              p_phase = PH_SKIP;
            end else begin
              p_pay_len = p_pay_len - 16'(UDP_HDR_BYTES);
              if (p_pay_len > cfg_max_pay) begin
                expect_result(KIND_STATUS, 8'd0, 1'b0, ST_TOO_LARGE,
                              p_sport, p_dport, p_pay_len);
                p_phase = PH_SKIP;
              end else if (p_pay_len == 16'd0) begin
                expect_result(KIND_EMPTY, 8'd0, 1'b0, ST_OK, p_sport, p_dport, 16'd0);
                p_phase = PH_SKIP;
              end else begin
                p_left  = p_pay_len;
                p_phase = PH_PAY;
              end
            end
          end
        end
        PH_PAY: begin
          p_consumed = p_consumed + 1;
          p_left = p_left - 16'd1;
          expect_result(KIND_PAYLOAD, b, p_left == 16'd0, ST_OK, p_sport, p_dport, p_pay_len);
          if (p_left == 16'd0) p_phase = PH_SKIP;
        end
        default: begin
          p_consumed = p_consumed + 1;
        end
      endcase
      if ((p_phase == PH_HDRS || p_phase == PH_PAY || p_phase == PH_SKIP) &&
          p_consumed >= p_rec_len) begin
        p_phase = PH_RHDR;
        p_pos   = '0;
      end
    end

    // Close the file and start over
    if (file_end) begin
      if (!p_halted && !(p_phase == PH_RHDR && p_pos == 16'd0)) end_st = ST_TRUNCATED;
      else end_st = ST_OK;
      expect_result(KIND_EOF, 8'd0, 1'b0, end_st, 16'd0, 16'd0, 16'd0);
      clear_parser();
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offer capture bytes and predict each accepted transfer
  always @(posedge clk) begin : drive_bytes
    capture_item_t next_item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_capture_byte(s_tdata, s_tlast);
        bytes_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (capture_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = capture_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.data;
          s_tlast  <= next_item.file_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Throttle the result side, with an occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (long_hold_req) begin
      m_tready  <= 1'b0;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(m_tuser));
        check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
        check_field("last_of_packet", 16'(want.last_of_packet), 16'(m_tlast));
        check_field("status", 16'(want.status), 16'(m_tdata[10:8]));
        check_field("src_port", want.src_port, m_tdata[26:11]);
        check_field("dst_port", want.dst_port, m_tdata[42:27]);
        check_field("payload_len", want.payload_len, m_tdata[58:43]);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FILTER_LINK:     cfg_link     = val[15:0];
      REG_FILTER_IP_SRC:   cfg_ip_src   = val;
      REG_FILTER_IP_DST:   cfg_ip_dst   = val;
      REG_FILTER_PROTO:    cfg_proto    = val[7:0];
      REG_FILTER_SRC_PORT: cfg_src_port = val[15:0];
      REG_FILTER_DST_PORT: cfg_dst_port = val[15:0];
      REG_MAX_PAYLOAD:     cfg_max_pay  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_filters(input logic [15:0] link, input logic [31:0] src,
                              input logic [31:0] dst, input logic [7:0] proto,
                              input logic [15:0] sp, input logic [15:0] dp,
                              input logic [15:0] maxp);
    cfg_write(REG_FILTER_LINK, {16'd0, link});
    cfg_write(REG_FILTER_IP_SRC, src);
    cfg_write(REG_FILTER_IP_DST, dst);
    cfg_write(REG_FILTER_PROTO, {24'd0, proto});
    cfg_write(REG_FILTER_SRC_PORT, {16'd0, sp});
    cfg_write(REG_FILTER_DST_PORT, {16'd0, dp});
    cfg_write(REG_MAX_PAYLOAD, {16'd0, maxp});
  endtask

  // Wait until every byte is taken and every result has come out
  task automatic drain();
    wait (bytes_accepted == bytes_queued && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_word(input logic swap, input logic [31:0] v);
    if (swap) begin
      file_buf.push_back(v[7:0]);
      file_buf.push_back(v[15:8]);
      file_buf.push_back(v[23:16]);
      file_buf.push_back(v[31:24]);
    end else begin
      file_buf.push_back(v[31:24]);
      file_buf.push_back(v[23:16]);
      file_buf.push_back(v[15:8]);
      file_buf.push_back(v[7:0]);
    end
  endtask

  task automatic put_ghdr(input logic swap, input logic [31:0] magic, input logic [31:0] link);
    put_word(swap, magic);
    repeat (16) file_buf.push_back(8'($urandom_range(0, 255)));
    put_word(swap, link);
  endtask

  // Record header plus body_n body bytes with the IP and UDP fields laid in
  task automatic put_record(input logic swap, input logic [31:0] rec_len,
                            input int unsigned body_n, input logic [7:0] proto,
                            input logic [31:0] src, input logic [31:0] dst,
                            input logic [15:0] sp, input logic [15:0] dp,
                            input logic [15:0] udp_len);
    logic [7:0] v;
    put_word(swap, $urandom());
    put_word(swap, $urandom());
    put_word(swap, rec_len);
    put_word(swap, $urandom());
    for (int unsigned i = 0; i < body_n; i++) begin
      v = 8'($urandom_range(0, 255));
      if (i == AT_PROTO) v = proto;
      else if (i >= 26 && i <= 29) v = src[8*(29-i) +: 8];
      else if (i >= 30 && i <= 33) v = dst[8*(33-i) +: 8];
      else if (i == 34 || i == 35) v = sp[8*(35-i) +: 8];
      else if (i == 36 || i == 37) v = dp[8*(37-i) +: 8];
      else if (i == 38 || i == 39) v = udp_len[8*(39-i) +: 8];
      file_buf.push_back(v);
    end
  endtask

  function automatic logic [31:0] pick_addr(input logic [31:0] f);
    if (f != 0 && $urandom_range(0, 3) != 0) return f;
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_port(input logic [15:0] f);
    if (f != 0 && $urandom_range(0, 3) != 0) return f;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic put_udp(input logic swap, input int unsigned pay, input int unsigned trail);
    int unsigned rl;
    rl = UDP_END + pay + trail;
    put_record(swap, rl, rl, UDP_PROTO, pick_addr(cfg_ip_src), pick_addr(cfg_ip_dst),
               pick_port(cfg_src_port), pick_port(cfg_dst_port), 16'(pay + UDP_HDR_BYTES));
  endtask

  // Push the file out as capture bytes, cut after 'cut' bytes unless zero
  task automatic ship_file(input int unsigned cut);
    capture_item_t it;
    int unsigned n;
    if (file_buf.size() == 0) file_buf.push_back(8'($urandom_range(0, 255)));
    n = (cut == 0 || cut > file_buf.size()) ? file_buf.size() : cut;
    for (int unsigned i = 0; i < n; i++) begin
      it.data     = file_buf[i];
      it.file_end = (i == n - 1);
      capture_bytes.push_back(it);
    end
    bytes_queued += n;
    phase_bytes  += n;
    file_buf.delete();
  endtask

  task automatic rand_record(input logic swap);
    int unsigned r;
    int unsigned pay;
    int unsigned rl;
    logic [7:0]  proto;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      case ($urandom_range(0, 9))
        0: pay = 0;
        1: pay = $urandom_range(25, 90);
        default: pay = $urandom_range(1, 24);
      endcase
      put_udp(swap, pay, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    end else if (r < 70) begin
      // non-UDP protocol, possibly the one the filter asks for
      proto = ($urandom_range(0, 1) == 0) ? cfg_proto : 8'($urandom_range(0, 255));
      if (proto == UDP_PROTO) proto = 8'd6;
      rl = $urandom_range(IP_END, 80);
      put_record(swap, rl, rl, proto, pick_addr(cfg_ip_src), pick_addr(cfg_ip_dst),
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end else if (r < 82) begin
      // too short for the IP header, or for the UDP header
      if (r < 76) rl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, IP_END - 1);
      else rl = $urandom_range(IP_END, UDP_END - 1);
      put_record(swap, rl, rl, UDP_PROTO, pick_addr(cfg_ip_src), pick_addr(cfg_ip_dst),
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end else if (r < 94) begin
      // UDP length below the header size or running past the record
      rl = $urandom_range(UDP_END, 60);
      put_record(swap, rl, rl, UDP_PROTO, pick_addr(cfg_ip_src), pick_addr(cfg_ip_dst),
                 pick_port(cfg_src_port), pick_port(cfg_dst_port),
                 (r < 88) ? 16'($urandom_range(0, UDP_HDR_BYTES - 1))
                          : 16'(rl - UDP_END + UDP_HDR_BYTES + $urandom_range(1, 10)));
    end else begin
      // payload around the size limit
      if (cfg_max_pay < 64) pay = cfg_max_pay + $urandom_range(0, 3);
      else pay = $urandom_range(1, 24);
      put_udp(swap, pay, 0);
    end
  endtask

  task automatic rand_file();
    logic        swap;
    logic [31:0] magic;
    logic [31:0] link;
    int unsigned nrec;
    swap  = 1'($urandom_range(0, 1));
    magic = WORD_MAGIC_NATIVE;
    if ($urandom_range(0, 99) < 4) begin
      magic = ($urandom_range(0, 1) == 0) ? $urandom()
                                          : WORD_MAGIC_NATIVE ^ (32'd1 << $urandom_range(0, 31));
      if (magic == WORD_MAGIC_NATIVE || magic == WORD_MAGIC_SWAPPED) magic = ~magic;
    end
    link = LINK_ETH;
    if ($urandom_range(0, 99) < 5) begin
      case ($urandom_range(0, 3))
        0: link = 32'd0;
        1: link = 32'd2;
        2: link = 32'hffffffff;
        default: link = $urandom();
      endcase
    end
    put_ghdr(swap, magic, link);
    nrec = $urandom_range(1, 4);
    repeat (nrec) rand_record(swap);
    if ($urandom_range(0, 9) == 0) ship_file($urandom_range(1, file_buf.size()));
    else ship_file(0);
  endtask

  task automatic rand_phase(input int unsigned budget);
    phase_bytes = 0;
    while (phase_bytes < budget) rand_file();
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  initial begin : stimulus
    cfg_link     = 16'd0;
    cfg_ip_src   = 32'd0;
    cfg_ip_dst   = 32'd0;
    cfg_proto    = 8'd0;
    cfg_src_port = 16'd0;
    cfg_dst_port = 16'd0;
    cfg_max_pay  = 16'd1500;
    clear_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Bad magic with trailing bytes ignored, then bad magic ending the file
    put_word(1'b0, WORD_MAGIC_NATIVE ^ 32'd1);
    repeat (6) file_buf.push_back(8'($urandom_range(0, 255)));
    ship_file(0);
    put_word(1'b1, 32'h12345678);
    ship_file(0);
    // Unsupported link, then a file cut inside the global header
    put_ghdr(1'b0, WORD_MAGIC_NATIVE, 32'd2);
    put_udp(1'b0, 3, 0);
    ship_file(0);
    put_ghdr(1'b1, WORD_MAGIC_NATIVE, LINK_ETH);
    ship_file(10);

    // Little-endian file through the empty, short, non-UDP, bad-length and payload record cases
    put_ghdr(1'b1, WORD_MAGIC_NATIVE, LINK_ETH);
    put_record(1'b1, 42, 42, UDP_PROTO, $urandom(), $urandom(), 16'h0000, 16'hffff, 16'd8);
    put_record(1'b1, 0, 0, UDP_PROTO, 0, 0, 0, 0, 0);
    put_record(1'b1, 20, 20, UDP_PROTO, 0, 0, 0, 0, 0);
    put_record(1'b1, 40, 40, UDP_PROTO, $urandom(), $urandom(), 16'd1, 16'd2, 16'd20);
    put_record(1'b1, 50, 50, 8'd6, $urandom(), $urandom(), 16'd1, 16'd2, 16'd16);
    put_record(1'b1, 45, 45, UDP_PROTO, $urandom(), $urandom(), 16'd1, 16'd2, 16'd5);
    put_record(1'b1, 50, 50, UDP_PROTO, $urandom(), $urandom(), 16'd1, 16'd2, 16'd31);
    put_udp(1'b1, 6, 3);
    put_record(1'b1, 47, 47, UDP_PROTO, $urandom(), $urandom(), 16'hffff, 16'h0000, 16'd13);
    ship_file(0);
    // Cut inside a record
    put_ghdr(1'b1, WORD_MAGIC_NATIVE, LINK_ETH);
    put_udp(1'b1, 10, 0);
    ship_file(24 + 16 + 30);
    drain();

    // Small size limit: over the limit, exactly at it, and empty
    cfg_write(REG_MAX_PAYLOAD, 32'd4);
    put_ghdr(1'b0, WORD_MAGIC_NATIVE, LINK_ETH);
    put_udp(1'b0, 5, 0);
    put_udp(1'b0, 4, 0);
    put_udp(1'b0, 0, 2);
    ship_file(0);
    drain();

    // Random files under several filter settings
    load_filters(16'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0, 16'd1500);
    rand_phase(PHASE_BYTES);
    drain();
    load_filters(16'd1, $urandom(), 32'd0, UDP_PROTO, 16'd0, 16'($urandom()), 16'd16);
    rand_phase(PHASE_BYTES);
    drain();

    set_idling(58, 17);
    load_filters(16'd0, 32'd0, $urandom(), 8'd0, 16'($urandom()), 16'd0, 16'd65535);
    rand_phase(PHASE_BYTES);
    drain();
    load_filters(16'd1, 32'hffffffff, 32'hffffffff, 8'hff, 16'hffff, 16'hffff, 16'd1);
    rand_phase(PHASE_BYTES);
    drain();

    set_idling(0, 0);
    load_filters(16'hffff, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0, 16'd1);
    rand_phase(80);
    drain();
    load_filters(16'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0, 16'd40);
    rand_phase(PHASE_BYTES);
    // Hold the result side so the result queue fills and the input stalls
    @(posedge clk);
    long_hold_req <= 1'b1;
    @(posedge clk);
    long_hold_req <= 1'b0;
    drain();

    if (errors == 0) begin
      $display("[pcap_udp_record_filter] OK");
    end else begin
      $display("[pcap_udp_record_filter] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pcuf_pkg.sv
src/pcuf_regs.sv
src/pcuf_parser.sv
src/pcuf_fifo.sv
src/pcap_udp_record_filter.sv
verif/tb_pcap_udp_record_filter.sv
